FILE: rtl/wrrs_pkg.sv
// wrrs_pkg: shared types and constants for the weighted round robin scheduler
// used by the controller, the datapath and the top level; no dependencies

package wrrs_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 16;
   localparam int WT_W        = 8;
   localparam int CMD_W       = 2;
   localparam int MODE_W      = 2;
   localparam int STAT_W      = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_NEXT   = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIFO = 2'd0,
      MODE_RR   = 2'd1,
      MODE_WRR  = 2'd2
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_SEARCH,
      FSM_SHIFT,
      FSM_GRANT,
      FSM_WRR,
      FSM_FALLBACK,
      FSM_RESP
   } fsm_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX_NEXT,
      RD_CURSOR,
      RD_FRONT
   } rd_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SEARCH_STEP,
      OP_UPDATE_WEIGHT,
      OP_APPEND,
      OP_SET_FULL,
      OP_SET_NOT_FOUND,
      OP_SET_EMPTY,
      OP_SHIFT_STEP,
      OP_REMOVE_DONE,
      OP_FIX_CURSOR,
      OP_GRANT_FRONT,
      OP_GRANT_RR,
      OP_WRR_STEP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      dp_op_type  op;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      mode_type mode;
      logic     empty;
      logic     full;
      logic     idx_at_count;
      logic     id_match;
      logic     shift_done;
      logic     wrr_hit;
      logic     tries_out;
      logic     out_free;
   } dp_stat_type;

endpackage

FILE: rtl/wrrs_ctrl.sv
// wrrs_ctrl: sequencer that walks the table for search, removal and grants
// depends on wrrs_pkg; drives wrrs_datapath through ctrl_cmd_type

module wrrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  wrrs_pkg::dp_stat_type stat,
   output wrrs_pkg::ctrl_cmd_type ctrl
);
   import wrrs_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) state_in = FSM_DECODE;
         end
         FSM_DECODE: begin
            case (stat.cmd)
               CMD_ADD, CMD_REMOVE: state_in = FSM_SEARCH;
               CMD_NEXT:            state_in = stat.empty ? FSM_RESP : FSM_GRANT;
               default:             state_in = FSM_RESP;
            endcase
         end
         FSM_SEARCH: begin
            if (stat.idx_at_count) begin
               state_in = FSM_RESP;
            end else if (stat.id_match) begin
               state_in = (stat.cmd == CMD_REMOVE) ? FSM_SHIFT : FSM_RESP;
            end
         end
         FSM_SHIFT: begin
            if (stat.shift_done) state_in = FSM_RESP;
         end
         FSM_GRANT: begin
            case (stat.mode)
               MODE_FIFO, MODE_RR: state_in = FSM_RESP;
               default:            state_in = FSM_WRR;
            endcase
         end
         FSM_WRR: begin
            if (stat.wrr_hit) begin
               state_in = FSM_RESP;
            end else if (stat.tries_out) begin
               state_in = FSM_FALLBACK;
            end
         end
         FSM_FALLBACK: state_in = FSM_RESP;
         FSM_RESP: begin
            if (stat.out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      req_tready  = 1'b0;
      ctrl.rd_sel = RD_IDX;
      ctrl.op     = OP_NONE;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) ctrl.op = OP_LOAD;
         end
         FSM_DECODE: begin
            if (stat.cmd == CMD_NEXT) begin
               ctrl.op = stat.empty ? OP_SET_EMPTY : OP_FIX_CURSOR;
            end
         end
         FSM_SEARCH: begin
            ctrl.rd_sel = RD_IDX;
            if (stat.idx_at_count) begin
               if (stat.cmd == CMD_REMOVE) begin
                  ctrl.op = OP_SET_NOT_FOUND;
               end else begin
                  ctrl.op = stat.full ? OP_SET_FULL : OP_APPEND;
               end
            end else if (stat.id_match) begin
               ctrl.op = (stat.cmd == CMD_REMOVE) ? OP_NONE : OP_UPDATE_WEIGHT;
            end else begin
               ctrl.op = OP_SEARCH_STEP;
            end
         end
         FSM_SHIFT: begin
            ctrl.rd_sel = RD_IDX_NEXT;
            ctrl.op     = stat.shift_done ? OP_REMOVE_DONE : OP_SHIFT_STEP;
         end
         FSM_GRANT: begin
            case (stat.mode)
               MODE_FIFO: begin
                  ctrl.rd_sel = RD_FRONT;
                  ctrl.op     = OP_GRANT_FRONT;
               end
               MODE_RR: begin
                  ctrl.rd_sel = RD_CURSOR;
                  ctrl.op     = OP_GRANT_RR;
               end
               default: ctrl.op = OP_NONE;
            endcase
         end
         FSM_WRR: begin
            ctrl.rd_sel = RD_CURSOR;
            ctrl.op     = OP_WRR_STEP;
         end
         FSM_FALLBACK: begin
            ctrl.rd_sel = RD_FRONT;
            ctrl.op     = OP_GRANT_FRONT;
         end
         FSM_RESP: begin
            if (stat.out_free) ctrl.op = OP_EMIT;
         end
         default: ctrl.op = OP_NONE;
      endcase
   end

endmodule

FILE: rtl/wrrs_datapath.sv
// wrrs_datapath: requester table, cursor, counters, mode register and result register
// depends on wrrs_pkg; executes one ctrl_cmd_type operation per cycle

module wrrs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  wrrs_pkg::ctrl_cmd_type       ctrl,
   output wrrs_pkg::dp_stat_type        stat,
   input  logic [wrrs_pkg::CMD_W-1:0]   req_command,
   input  logic [wrrs_pkg::ID_W-1:0]    req_entry_id,
   input  logic [wrrs_pkg::WT_W-1:0]    req_weight,
   input  logic                         csr_we,
   input  logic [wrrs_pkg::MODE_W-1:0]  csr_wdata,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic                         rsp_grant_valid,
   output logic [wrrs_pkg::ID_W-1:0]    rsp_grant_id,
   output logic [wrrs_pkg::STAT_W-1:0]  rsp_status,
   output logic [wrrs_pkg::CNT_W-1:0]   rsp_entry_count
);
   import wrrs_pkg::*;

   // table, no reset: only entries below the count are ever used
   logic [ID_W-1:0]  ids_ff     [MAX_ENTRIES];
   logic [WT_W-1:0]  weights_ff [MAX_ENTRIES];
   logic [WT_W-1:0]  credits_ff [MAX_ENTRIES];

   logic [CNT_W-1:0] count_ff,  count_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] idx_ff,    idx_in;
   logic [CNT_W-1:0] tries_ff,  tries_in;
   cmd_type          cmd_ff,    cmd_in;
   logic [ID_W-1:0]  id_ff,     id_in;
   logic [WT_W-1:0]  wt_ff,     wt_in;
   mode_type         mode_ff,   mode_in;
   logic             gvalid_ff, gvalid_in;
   logic [ID_W-1:0]  gid_ff,    gid_in;
   status_type       status_ff, status_in;

   logic             rsp_valid_ff,  rsp_valid_in;
   logic             rsp_gvalid_ff, rsp_gvalid_in;
   logic [ID_W-1:0]  rsp_gid_ff,    rsp_gid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff,  rsp_count_in;

   logic [IDX_W-1:0] rd_addr;
   logic [ID_W-1:0]  rd_id;
   logic [WT_W-1:0]  rd_wt;
   logic [WT_W-1:0]  rd_cr;
   logic [CNT_W-1:0] idx_plus1;
   logic [CNT_W-1:0] cursor_plus1;
   logic [IDX_W-1:0] cursor_adv;
   logic [CNT_W-1:0] count_dec;

   logic             we_id, we_wt, we_cr;
   logic [IDX_W-1:0] wr_addr;
   logic [ID_W-1:0]  wr_id;
   logic [WT_W-1:0]  wr_wt;
   logic [WT_W-1:0]  wr_cr;

   assign idx_plus1    = idx_ff + CNT_W'(1);
   assign cursor_plus1 = CNT_W'(cursor_ff) + CNT_W'(1);
   assign cursor_adv   = (cursor_plus1 >= count_ff) ? '0 : cursor_plus1[IDX_W-1:0];
   assign count_dec    = count_ff - CNT_W'(1);

   // single read port, address chosen by controller state
   always_comb begin
      case (ctrl.rd_sel)
         RD_IDX:      rd_addr = idx_ff[IDX_W-1:0];
         RD_IDX_NEXT: rd_addr = idx_plus1[IDX_W-1:0];
         RD_CURSOR:   rd_addr = cursor_ff;
         RD_FRONT:    rd_addr = '0;
         default:     rd_addr = '0;
      endcase
   end

   assign rd_id = ids_ff[rd_addr];
   assign rd_wt = weights_ff[rd_addr];
   assign rd_cr = credits_ff[rd_addr];

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      tries_in  = tries_ff;
      cmd_in    = cmd_ff;
      id_in     = id_ff;
      wt_in     = wt_ff;
      gvalid_in = gvalid_ff;
      gid_in    = gid_ff;
      status_in = status_ff;
      we_id     = 1'b0;
      we_wt     = 1'b0;
      we_cr     = 1'b0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_id     = rd_id;
      wr_wt     = rd_wt;
      wr_cr     = rd_cr;

      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_gvalid_in = rsp_gvalid_ff;
      rsp_gid_in    = rsp_gid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      mode_in = csr_we ? mode_type'(csr_wdata) : mode_ff;

      case (ctrl.op)
         OP_LOAD: begin
            cmd_in    = cmd_type'(req_command);
            id_in     = req_entry_id;
            wt_in     = req_weight;
            idx_in    = '0;
            tries_in  = '0;
            gvalid_in = 1'b0;
            gid_in    = '0;
            status_in = ST_OK;
         end
         OP_SEARCH_STEP: idx_in = idx_plus1;
         OP_UPDATE_WEIGHT: begin
            we_wt = 1'b1;
            wr_wt = wt_ff;
         end
         OP_APPEND: begin
            wr_addr  = count_ff[IDX_W-1:0];
            we_id    = 1'b1;
            we_wt    = 1'b1;
            we_cr    = 1'b1;
            wr_id    = id_ff;
            wr_wt    = wt_ff;
            wr_cr    = wt_ff;
            count_in = count_ff + CNT_W'(1);
         end
         OP_SET_FULL:      status_in = ST_FULL;
         OP_SET_NOT_FOUND: status_in = ST_NOT_FOUND;
         OP_SET_EMPTY:     status_in = ST_EMPTY;
         OP_SHIFT_STEP: begin
            // entry at idx takes the one behind it
            we_id  = 1'b1;
            we_wt  = 1'b1;
            we_cr  = 1'b1;
            idx_in = idx_plus1;
         end
         OP_REMOVE_DONE: begin
            count_in = count_dec;
            if (CNT_W'(cursor_ff) >= count_dec) cursor_in = '0;
         end
         OP_FIX_CURSOR: begin
            if (CNT_W'(cursor_ff) >= count_ff) cursor_in = '0;
         end
         OP_GRANT_FRONT: begin
            gvalid_in = 1'b1;
            gid_in    = rd_id;
         end
         OP_GRANT_RR: begin
            gvalid_in = 1'b1;
            gid_in    = rd_id;
            cursor_in = cursor_adv;
         end
         OP_WRR_STEP: begin
            wr_addr   = cursor_ff;
            we_cr     = 1'b1;
            gvalid_in = 1'b1;
            if (rd_cr != '0) begin
               gid_in = rd_id;
               if (rd_cr == WT_W'(1)) begin
                  wr_cr     = rd_wt;
                  cursor_in = cursor_adv;
               end else begin
                  wr_cr = rd_cr - WT_W'(1);
               end
            end else begin
               // fruitless try: reload and move on
               wr_cr     = rd_wt;
               cursor_in = cursor_adv;
               tries_in  = tries_ff + CNT_W'(1);
            end
         end
         OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_gvalid_in = gvalid_ff;
            rsp_gid_in    = gid_ff;
            rsp_status_in = status_ff;
            rsp_count_in  = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_id) ids_ff[wr_addr]     <= wr_id;
      if (we_wt) weights_ff[wr_addr] <= wr_wt;
      if (we_cr) credits_ff[wr_addr] <= wr_cr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         mode_ff      <= MODE_WRR;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tries_ff      <= tries_in;
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      wt_ff         <= wt_in;
      gvalid_ff     <= gvalid_in;
      gid_ff        <= gid_in;
      status_ff     <= status_in;
      rsp_gvalid_ff <= rsp_gvalid_in;
      rsp_gid_ff    <= rsp_gid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      stat.cmd          = cmd_ff;
      stat.mode         = mode_ff;
      stat.empty        = (count_ff == '0);
      stat.full         = (count_ff == CNT_W'(MAX_ENTRIES));
      stat.idx_at_count = (idx_ff == count_ff);
      stat.id_match     = (rd_id == id_ff);
      stat.shift_done   = (idx_plus1 >= count_ff);
      stat.wrr_hit      = (rd_cr != '0);
      stat.tries_out    = (tries_ff >= count_ff);
      stat.out_free     = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_grant_valid = rsp_gvalid_ff;
   assign rsp_grant_id    = rsp_gid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/weighted_round_robin_scheduler.sv
// weighted_round_robin_scheduler: top level, stream ports and field packing
// depends on wrrs_pkg, wrrs_ctrl and wrrs_datapath
//
// Usage: one command beat enters on req_ (tuser = command, tdata = entry_id,
// weight) and exactly one result beat leaves on rsp_ (tuser = grant_valid,
// tdata = grant_id, status, entry_count). csr_we writes sched_mode; the user
// is to write it only while no command is in flight; the block does not
// enforce this. Add searches for the id, then updates a match's weight or
// appends; remove searches, then shifts every entry behind the match down
// one slot; next grants the front entry in fifo mode, the cursor entry in
// round robin mode, and in weighted mode visits entries from the cursor
// until one has credit, else the front; an empty table or a no-op code goes
// straight to the result. The table has a single read port; the sequencer
// visits one entry a cycle. One command is worked on at a time; the next is
// taken from the cycle after the result is registered.
// Reset (synchronous, active high) empties the table, zeroes the cursor and
// selects weighted round robin. If rsp_tready is held low the result stays in
// the output register and a finished command waits until the register frees.

module weighted_round_robin_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] entry_id, [23:16] weight
   input  logic [wrrs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  logic [wrrs_pkg::CMD_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] grant_id, [17:16] status, [22:18] entry_count, [23] zero
   output logic [wrrs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] grant_valid
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [wrrs_pkg::MODE_W-1:0]      csr_wdata
);
   import wrrs_pkg::*;

   ctrl_cmd_type     ctrl;
   dp_stat_type      stat;
   logic [ID_W-1:0]  grant_id;
   logic [STAT_W-1:0] status;
   logic [CNT_W-1:0] entry_count;

   wrrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   wrrs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_command     (req_tuser),
      .req_entry_id    (req_tdata[ID_W-1:0]),
      .req_weight      (req_tdata[ID_W+WT_W-1:ID_W]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_grant_valid (rsp_tuser),
      .rsp_grant_id    (grant_id),
      .rsp_status      (status),
      .rsp_entry_count (entry_count)
   );

   assign rsp_tdata = {{(RSP_DATA_W-ID_W-STAT_W-CNT_W){1'b0}}, entry_count, status, grant_id};

endmodule

FILE: tb/tb_weighted_round_robin_scheduler.sv
// tb_weighted_round_robin_scheduler: self-checking testbench for the scheduler top level
// depends on wrrs_pkg and weighted_round_robin_scheduler; keeps its own table model
// and scores every rsp_ beat against it, with random stalls on both stream sides

`timescale 1ns / 100ps

module tb_weighted_round_robin_scheduler;
   import wrrs_pkg::*;

   // codes that the package enums leave out
   localparam logic [CMD_W-1:0]  CMD_NOP    = 2'd3;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic              grant_valid;
      logic [ID_W-1:0]   grant_id;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  entry_count;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [MODE_W-1:0]     csr_wdata;

   // table model
   logic [ID_W-1:0]   tbl_id     [MAX_ENTRIES];
   logic [WT_W-1:0]   tbl_wt     [MAX_ENTRIES];
   logic [WT_W-1:0]   tbl_credit [MAX_ENTRIES];
   int                tbl_count  = 0;
   int                tbl_cursor = 0;
   logic [MODE_W-1:0] grant_mode = MODE_WRR;

   sched_result_type pending_results [$];
   int commands_sent = 0;
   int results_seen  = 0;
   int fail_count    = 0;
   int n_grants = 0, n_full = 0, n_not_found = 0, n_empty = 0;
   bit idle_on   = 1'b1;
   int hold_cycles = 0;
   int rsp_gap     = 0;

   weighted_round_robin_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void advance_slot();
      tbl_cursor = (tbl_cursor + 1 >= tbl_count) ? 0 : tbl_cursor + 1;
   endfunction

   function automatic sched_result_type schedule_outcome(input logic [CMD_W-1:0] op,
         input logic [ID_W-1:0] id, input logic [WT_W-1:0] wt);
      sched_result_type r;
      int pos;
      int tries;
      int c;
      bit done;
      r.grant_valid = 1'b0;
      r.grant_id    = '0;
      r.status      = ST_OK;
      pos   = -1;
      tries = 0;
      done  = 1'b0;
      for (int i = 0; i < tbl_count; i++)
         if (pos < 0 && tbl_id[i] == id) pos = i;
      case (op)
         CMD_ADD: begin
            if (pos >= 0) begin
               tbl_wt[pos] = wt;
            end else if (tbl_count < MAX_ENTRIES) begin
               tbl_id[tbl_count]     = id;
               tbl_wt[tbl_count]     = wt;
               tbl_credit[tbl_count] = wt;
               tbl_count++;
            end else begin
               r.status = ST_FULL;
            end
         end
         CMD_REMOVE: begin
            if (pos < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < tbl_count; i++) begin
                  tbl_id[i]     = tbl_id[i + 1];
                  tbl_wt[i]     = tbl_wt[i + 1];
                  tbl_credit[i] = tbl_credit[i + 1];
               end
               tbl_count--;
               if (tbl_cursor >= tbl_count) tbl_cursor = 0;
            end
         end
         CMD_NEXT: begin
            if (tbl_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (tbl_cursor >= tbl_count) tbl_cursor = 0;
               r.grant_valid = 1'b1;
               if (grant_mode == MODE_FIFO) begin
                  r.grant_id = tbl_id[0];
               end else if (grant_mode == MODE_RR) begin
                  r.grant_id = tbl_id[tbl_cursor];
                  advance_slot();
               end else begin
                  // weighted: spare mode code lands here too
                  while (!done && tries <= tbl_count) begin
                     c = tbl_cursor;
                     if (tbl_credit[c] > 0) begin
                        tbl_credit[c] = tbl_credit[c] - 1'b1;
                        r.grant_id = tbl_id[c];
                        if (tbl_credit[c] == 0) begin
                           tbl_credit[c] = tbl_wt[c];
                           advance_slot();
                        end
                        done = 1'b1;
                     end else begin
                        tbl_credit[c] = tbl_wt[c];
                        advance_slot();
                        tries++;
                     end
                  end
                  // every entry came up dry, fall back to the front
                  if (!done) r.grant_id = tbl_id[0];
               end
            end
         end
         default: ;
      endcase
      r.entry_count = tbl_count[CNT_W-1:0];
      return r;
   endfunction

   // predict on accepted req_ beats, score accepted rsp_ beats
   always @(posedge clock) begin : score_beats
      sched_result_type want;
      if (!reset) begin
         if (csr_we) grant_mode = csr_wdata;
         if (req_tvalid && req_tready) begin
            want = schedule_outcome(req_tuser, req_tdata[15:0], req_tdata[23:16]);
            pending_results.insert(pending_results.size(), want);
            if (want.grant_valid) n_grants++;
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_NOT_FOUND) n_not_found++;
            if (want.status == ST_EMPTY) n_empty++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no command outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.grant_valid) begin
                  $error("grant_valid: expected %0d, got %0d", want.grant_valid, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[15:0] !== want.grant_id) begin
                  $error("grant_id: expected %h, got %h", want.grant_id, rsp_tdata[15:0]);
                  fail_count++;
               end
               if (rsp_tdata[17:16] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[17:16]);
                  fail_count++;
               end
               if (rsp_tdata[22:18] !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count,
                         rsp_tdata[22:18]);
                  fail_count++;
               end
            end
            results_seen++;
         end
      end
   end

   // result side: long hold when asked, else random stall bursts while idle_on is set
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // returns at the edge that took the beat, tvalid still high
   task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
         input logic [WT_W-1:0] wt);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wt, id};
      do @(posedge clock); while (!req_tready);
      commands_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_seen < commands_sent);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] mode_val);
      csr_we    <= 1'b1;
      csr_wdata <= mode_val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // empty table, missing id, no-op code, fill to the limit, refused add,
   // weight update below the remaining credits
   task automatic test_table_limits();
      logic [WT_W-1:0] wt;
      send_cmd(CMD_NEXT, 16'h0000, 8'h00);
      send_cmd(CMD_REMOVE, 16'h1234, 8'h00);
      send_cmd(CMD_NOP, 16'hFFFF, 8'hFF);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         wt = (i == 1) ? 8'd2 : (i == 3) ? 8'hFF : 8'(i % 5);
         send_cmd(CMD_ADD, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h0101), wt);
      end
      send_cmd(CMD_ADD, 16'h7777, 8'h01);
      send_cmd(CMD_ADD, 16'hFFFF, 8'h01);
      repeat (3) send_cmd(CMD_NEXT, 16'h0000, 8'h00);
      wait_drained();
   endtask

   // receiver holds off long enough for the request side to back up
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_cycles = 300;
      for (int n = 0; n < 12; n++)
         send_cmd((n % 3 == 0) ? CMD_ADD : CMD_NEXT, 16'(n * 7), 8'(n % 4));
      wait_drained();
   endtask

   task automatic test_random_phases();
      logic [MODE_W-1:0] phase_mode [10];
      logic [ID_W-1:0]   id_pool [24];
      logic [CMD_W-1:0]  op;
      logic [ID_W-1:0]   id;
      logic [WT_W-1:0]   wt;
      int add_pct;
      int remove_pct;
      int zero_pct;
      int r;
      phase_mode = '{MODE_RR, MODE_FIFO, MODE_SPARE, MODE_WRR, MODE_RR,
                     MODE_WRR, MODE_FIFO, MODE_SPARE, MODE_WRR, MODE_RR};
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 24; i++) id_pool[i] = 16'($urandom);
      for (int p = 0; p < 10; p++) begin
         wait_drained();
         idle_on = (p < 8) && (p != 3);
         write_mode(phase_mode[p]);
         case (p % 3)
            0: begin add_pct = 50; remove_pct = 10; end
            1: begin add_pct = 30; remove_pct = 25; end
            default: begin add_pct = 20; remove_pct = 40; end
         endcase
         // one phase leans on zero weights so whole tables run dry
         zero_pct = (p == 5) ? 80 : 10;
         for (int n = 0; n < 115; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) op = CMD_NOP;
            else if (r < 2 + add_pct) op = CMD_ADD;
            else if (r < 2 + add_pct + remove_pct) op = CMD_REMOVE;
            else op = CMD_NEXT;
            id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 23)]
                                              : 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < zero_pct) wt = 8'h00;
            else if (r < zero_pct + 5) wt = 8'hFF;
            else if (r < zero_pct + 15) wt = 8'($urandom);
            else wt = 8'($urandom_range(1, 4));
            send_cmd(op, id, wt);
         end
      end
      wait_drained();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_limits();
      test_output_stall();
      test_random_phases();

      repeat (40) @(posedge clock);
      $display("covered %0d commands over all four mode codes: %0d grants, %0d empty-table nexts",
               commands_sent, n_grants, n_empty);
      $display("  %0d adds refused on a full table, %0d removes of absent ids, stalls on both sides",
               n_full, n_not_found);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("** weighted_round_robin_scheduler: PASSED **");
      else
         $display("** weighted_round_robin_scheduler: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** weighted_round_robin_scheduler: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
rtl/wrrs_pkg.sv
rtl/wrrs_ctrl.sv
rtl/wrrs_datapath.sv
rtl/weighted_round_robin_scheduler.sv
tb/tb_weighted_round_robin_scheduler.sv
